// ===== hdl/wps_pkg.sv =====
// Shared types, constants and helper functions for the WAV PCM stream parser.
`timescale 1ns / 1ps

package wps_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_STOP
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NOT_RIFF    = 3'd0;
  localparam logic [2:0] ERR_NOT_WAVE    = 3'd1;
  localparam logic [2:0] ERR_BAD_TAG     = 3'd2;
  localparam logic [2:0] ERR_NOT_PCM     = 3'd3;
  localparam logic [2:0] ERR_UNSUPPORTED = 3'd4;

  // Tags as little-endian words: the first byte of the stream sits in bits 7:0.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FORMAT_PCM = 16'd1;

  // Byte of a tag word at a given position within the tag.
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = tag[7:0];
      2'd1: b = tag[15:8];
      2'd2: b = tag[23:16];
      default: b = tag[31:24];
    endcase
    return b;
  endfunction

  // Mean of two signed samples, rounded toward minus infinity.
  function automatic logic signed [15:0] avg_floor(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    return s[16:1];
  endfunction

endpackage

// ===== hdl/wav_pcm_stream_parser.sv =====
// Top level of the WAV PCM stream parser: header checks, field capture and sample decoding.
`timescale 1ns / 1ps

// Takes a WAV file one byte per request and checks its fixed 44-byte RIFF/PCM
// header, then returns one mono Q1.15 sample per frame, with stereo frames
// averaged and the final frame flagged. A header result reports channels,
// sample rate, depth and frame count; an error result stops parsing until a
// byte marked with first_byte arrives. The block takes one byte every cycle
// unless a waiting result is stalled: each byte is decoded by short logic
// straight into the result register, so a result is registered in the cycle
// after its byte, and the next byte enters while it waits if out_ready takes it.
module wav_pcm_stream_parser
  import wps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic signed [15:0] sample,
  output logic               last_sample,
  output logic [2:0]         error_code,
  output logic [1:0]         channels,
  output logic [31:0]        rate_hz,
  output logic [4:0]         bits_per_sample,
  output logic [31:0]        frame_count
);

  phase_t      phase, phase_next, cur_phase;
  logic [5:0]  header_position, header_position_next, cur_position;
  logic [31:0] field_shift, field_shift_next, cur_field_shift, shifted;
  logic [15:0] format_word, format_word_next, cur_format_word;
  logic [1:0]  channel_count, channel_count_next, cur_channel_count;
  logic        depth_is_sixteen, depth_is_sixteen_next, cur_depth_is_sixteen;
  logic [31:0] rate_value, rate_value_next, cur_rate_value;
  logic [31:0] frames_left, frames_left_next, cur_frames_left;
  logic [1:0]  byte_in_frame, byte_in_frame_next, cur_byte_in_frame;
  logic [15:0] partial_sample, partial_sample_next, cur_partial_sample;

  logic               take;
  logic               res_valid;
  logic [1:0]         res_kind;
  logic signed [15:0] res_sample;
  logic               res_last;
  logic [2:0]         res_error;
  logic [1:0]         res_channels;
  logic [31:0]        res_rate;
  logic [4:0]         res_bits;
  logic [31:0]        res_frames;

  logic [15:0]        upper_half;
  logic [1:0]         frame_shift;
  logic [31:0]        frames_total;
  logic signed [15:0] byte_value;
  logic [15:0]        word_value;
  logic signed [15:0] emit_value;
  logic               emit;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // A marked byte sees the state as it is right after reset.
  always_comb begin
    if (first_byte) begin
      cur_phase            = PH_HEADER;
      cur_position         = '0;
      cur_field_shift      = '0;
      cur_format_word      = '0;
      cur_channel_count    = 2'd1;
      cur_depth_is_sixteen = 1'b0;
      cur_rate_value       = '0;
      cur_frames_left      = '0;
      cur_byte_in_frame    = '0;
      cur_partial_sample   = '0;
    end else begin
      cur_phase            = phase;
      cur_position         = header_position;
      cur_field_shift      = field_shift;
      cur_format_word      = format_word;
      cur_channel_count    = channel_count;
      cur_depth_is_sixteen = depth_is_sixteen;
      cur_rate_value       = rate_value;
      cur_frames_left      = frames_left;
      cur_byte_in_frame    = byte_in_frame;
      cur_partial_sample   = partial_sample;
    end
  end

  always_comb begin
    shifted      = {data_byte, cur_field_shift[31:8]};
    upper_half   = shifted[31:16];
    frame_shift  = {1'b0, cur_channel_count == 2'd2} + {1'b0, cur_depth_is_sixteen};
    frames_total = shifted >> frame_shift;
    byte_value   = {data_byte ^ 8'h80, 8'h00};
    word_value   = '0;
    emit_value   = '0;
    emit         = 1'b0;

    phase_next            = cur_phase;
    header_position_next  = cur_position;
    field_shift_next      = cur_field_shift;
    format_word_next      = cur_format_word;
    channel_count_next    = cur_channel_count;
    depth_is_sixteen_next = cur_depth_is_sixteen;
    rate_value_next       = cur_rate_value;
    frames_left_next      = cur_frames_left;
    byte_in_frame_next    = cur_byte_in_frame;
    partial_sample_next   = cur_partial_sample;

    res_valid    = 1'b0;
    res_kind     = KIND_SAMPLE;
    res_sample   = '0;
    res_last     = 1'b0;
    res_error    = ERR_NOT_RIFF;
    res_channels = '0;
    res_rate     = '0;
    res_bits     = '0;
    res_frames   = '0;

    case (cur_phase)
      PH_HEADER: begin
        field_shift_next     = shifted;
        header_position_next = cur_position + 6'd1;
        if (cur_position <= 6'd3) begin
          if (data_byte != tag_byte(TAG_RIFF, cur_position[1:0])) begin
            res_valid = 1'b1;
            res_error = ERR_NOT_RIFF;
          end
        end else if (cur_position >= 6'd8 && cur_position <= 6'd11) begin
          if (data_byte != tag_byte(TAG_WAVE, cur_position[1:0])) begin
            res_valid = 1'b1;
            res_error = ERR_NOT_WAVE;
          end
        end else if (cur_position >= 6'd12 && cur_position <= 6'd15) begin
          if (data_byte != tag_byte(TAG_FMT, cur_position[1:0])) begin
            res_valid = 1'b1;
            res_error = ERR_BAD_TAG;
          end
        end else if (cur_position == 6'd21) begin
          format_word_next = upper_half;
        end else if (cur_position == 6'd23) begin
          channel_count_next = (upper_half == 16'd1 || upper_half == 16'd2) ?
                               upper_half[1:0] : 2'd0;
        end else if (cur_position == 6'd27) begin
          rate_value_next = shifted;
        end else if (cur_position == 6'd35) begin
          if (cur_format_word != FORMAT_PCM) begin
            res_valid = 1'b1;
            res_error = ERR_NOT_PCM;
          end else if (cur_channel_count == 2'd0 ||
                       (upper_half != 16'd8 && upper_half != 16'd16)) begin
            res_valid = 1'b1;
            res_error = ERR_UNSUPPORTED;
          end else begin
            depth_is_sixteen_next = (upper_half == 16'd16);
          end
        end else if (cur_position >= 6'd36 && cur_position <= 6'd39) begin
          if (data_byte != tag_byte(TAG_DATA, cur_position[1:0])) begin
            res_valid = 1'b1;
            res_error = ERR_BAD_TAG;
          end
        end else if (cur_position == 6'd43) begin
          frames_left_next   = frames_total;
          byte_in_frame_next = '0;
          phase_next         = (frames_total == '0) ? PH_STOP : PH_DATA;
          res_valid          = 1'b1;
          res_kind           = KIND_HEADER;
          res_channels       = cur_channel_count;
          res_rate           = cur_rate_value;
          res_bits           = cur_depth_is_sixteen ? 5'd16 : 5'd8;
          res_frames         = frames_total;
        end
        // Any tag or format failure takes the error path.
        if (res_valid && res_kind == KIND_SAMPLE) begin
          res_kind   = KIND_ERROR;
          phase_next = PH_STOP;
        end
      end

      PH_DATA: begin
        if (!cur_depth_is_sixteen) begin
          if (cur_channel_count != 2'd2) begin
            emit       = 1'b1;
            emit_value = byte_value;
          end else if (cur_byte_in_frame == 2'd0) begin
            partial_sample_next = byte_value;
            byte_in_frame_next  = 2'd1;
          end else begin
            emit       = 1'b1;
            emit_value = avg_floor(cur_partial_sample, byte_value);
          end
        end else begin
          case (cur_byte_in_frame)
            2'd0: begin
              partial_sample_next = {8'h00, data_byte};
              byte_in_frame_next  = 2'd1;
            end
            2'd1: begin
              word_value = {data_byte, cur_partial_sample[7:0]};
              if (cur_channel_count != 2'd2) begin
                emit       = 1'b1;
                emit_value = word_value;
              end else begin
                partial_sample_next = word_value;
                byte_in_frame_next  = 2'd2;
              end
            end
            2'd2: begin
              // The right channel's low byte waits in the field assembler.
              field_shift_next   = {24'h0, data_byte};
              byte_in_frame_next = 2'd3;
            end
            default: begin
              word_value = {data_byte, cur_field_shift[7:0]};
              emit       = 1'b1;
              emit_value = avg_floor(cur_partial_sample, word_value);
            end
          endcase
        end
        if (emit) begin
          res_valid          = 1'b1;
          res_kind           = KIND_SAMPLE;
          res_sample         = emit_value;
          res_last           = (cur_frames_left == 32'd1);
          frames_left_next   = cur_frames_left - 32'd1;
          byte_in_frame_next = '0;
          if (cur_frames_left == 32'd1) begin
            phase_next = PH_STOP;
          end
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      header_position  <= '0;
      field_shift      <= '0;
      format_word      <= '0;
      channel_count    <= 2'd1;
      depth_is_sixteen <= 1'b0;
      rate_value       <= '0;
      frames_left      <= '0;
      byte_in_frame    <= '0;
      partial_sample   <= '0;
    end else if (take) begin
      phase            <= phase_next;
      header_position  <= header_position_next;
      field_shift      <= field_shift_next;
      format_word      <= format_word_next;
      channel_count    <= channel_count_next;
      depth_is_sixteen <= depth_is_sixteen_next;
      rate_value       <= rate_value_next;
      frames_left      <= frames_left_next;
      byte_in_frame    <= byte_in_frame_next;
      partial_sample   <= partial_sample_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      kind            <= res_kind;
      sample          <= res_sample;
      last_sample     <= res_last;
      error_code      <= res_error;
      channels        <= res_channels;
      rate_hz         <= res_rate;
      bits_per_sample <= res_bits;
      frame_count     <= res_frames;
    end
  end

endmodule

// ===== hdl/wps_checker.sv =====
// Port-level checker for the WAV PCM stream parser, bound to the top level.
`timescale 1ns / 1ps

module wps_checker
  import wps_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         kind,
  input logic signed [15:0] sample,
  input logic               last_sample,
  input logic [2:0]         error_code,
  input logic [1:0]         channels,
  input logic [31:0]        rate_hz,
  input logic [4:0]         bits_per_sample,
  input logic [31:0]        frame_count
);

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(sample) &&
      $stable(last_sample) && $stable(error_code) && $stable(channels) &&
      $stable(rate_hz) && $stable(bits_per_sample) && $stable(frame_count))
    else $error("result changed while stalled");

  // The output register frees space for the next request when its result is taken.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while the result was taken");

  a_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_HEADER |->
      (channels == 2'd1 || channels == 2'd2) &&
      (bits_per_sample == 5'd8 || bits_per_sample == 5'd16))
    else $error("header result with unsupported format");

  a_sample_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_SAMPLE |->
      channels == 2'd0 && frame_count == 32'd0 && error_code == ERR_NOT_RIFF)
    else $error("sample result carries header or error fields");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind wav_pcm_stream_parser wps_checker u_wps_checker (.*);
